/* src/meter_style_command_framer_core_assert.svh */
// Assertion macros shared by the framer RTL files.
// No dependencies; define SYNTHESIS to compile them away.
`ifndef METER_STYLE_COMMAND_FRAMER_CORE_ASSERT_SVH
`define METER_STYLE_COMMAND_FRAMER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define MSCF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed (same cycle)");
// Next-cycle implication, disabled while in reset.
`define MSCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed (next cycle)");
`else
`define MSCF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MSCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/mscf_pkg.sv */
// Shared types, constants and frame byte functions for the command framer.
// No dependencies.
`default_nettype none

package mscf_pkg;

    localparam logic [7:0] ADDR_BYTE  = 8'hAA;
    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] CTRL_QUERY = 8'h11;
    localparam logic [7:0] CTRL_WRITE = 8'h14;
    localparam logic [7:0] DOMAIN_ADD = 8'h33;
    localparam logic [7:0] LEN_QUERY  = 8'd4;
    localparam logic [7:0] LEN_WRITE  = 8'd12;

    localparam logic [31:0] IDENT_BASE = 32'h0400_0300;

    localparam logic [7:0] PASSWORD [8] = '{
        8'h02, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D
    };

    // Byte positions within the frame
    typedef logic [4:0] idx_t;
    localparam idx_t IDX_START      = 5'd6;
    localparam idx_t IDX_CTRL       = 5'd7;
    localparam idx_t IDX_LEN        = 5'd8;
    localparam idx_t IDX_ID0        = 5'd9;
    localparam idx_t IDX_ID1        = 5'd10;
    localparam idx_t IDX_ID2        = 5'd11;
    localparam idx_t IDX_ID3        = 5'd12;
    localparam idx_t IDX_PWD        = 5'd13;
    localparam idx_t IDX_PARAM      = 5'd21;
    localparam idx_t IDX_CSUM_QUERY = 5'd13;
    localparam idx_t IDX_CSUM_WRITE = 5'd21;
    localparam idx_t IDX_CSUM_PARAM = 5'd22;

    // Command codes
    typedef enum logic [3:0] {
        KIND_STATE      = 4'd0,
        KIND_TUNE       = 4'd1,
        KIND_FLASH_GEAR = 4'd2,
        KIND_FREQ_GEAR  = 4'd3,
        KIND_GEAR_A     = 4'd4,
        KIND_GEAR_B     = 4'd5,
        KIND_GEAR_C     = 4'd6,
        KIND_WORKTIME   = 4'd7,
        KIND_LIGHTSENSE = 4'd8,
        KIND_SYNC_A     = 4'd9,
        KIND_SYNC_B     = 4'd10,
        KIND_SYNC_C     = 4'd11,
        KIND_TEST_A     = 4'd12,
        KIND_TEST_B     = 4'd13
    } kind_t;

    // Identifier low byte codes
    localparam logic [2:0] LOW_NONE       = 3'd0;
    localparam logic [2:0] LOW_GEAR       = 3'd2;
    localparam logic [2:0] LOW_SYNC       = 3'd3;
    localparam logic [2:0] LOW_WORK       = 3'd4;
    localparam logic [2:0] LOW_WORK_FLASH = 3'd5;
    localparam logic [2:0] LOW_TUNE       = 3'd6;
    localparam logic [2:0] LOW_TUNE_FLASH = 3'd7;

    localparam int unsigned QDEPTH = 2;

    typedef struct packed {
        logic       query;
        logic       has_param;
        logic [2:0] low;
        logic [7:0] param;
    } frame_desc_t;

    // Position of the checksum byte
    function automatic idx_t body_len(frame_desc_t d);
        idx_t n;
        if (d.query)
            n = IDX_CSUM_QUERY;
        else if (d.has_param)
            n = IDX_CSUM_PARAM;
        else
            n = IDX_CSUM_WRITE;
        return n;
    endfunction

    // Frame byte at a position before the checksum
    function automatic logic [7:0] frame_byte(frame_desc_t d, idx_t idx);
        logic [7:0] b;
        idx_t       pwd_off;
        pwd_off = idx - IDX_PWD;
        priority if (idx < IDX_START)
            b = ADDR_BYTE;
        else if (idx == IDX_START)
            b = START_BYTE;
        else if (idx == IDX_CTRL)
            b = d.query ? CTRL_QUERY : CTRL_WRITE;
        else if (idx == IDX_LEN)
            b = d.query ? LEN_QUERY : (LEN_WRITE + {7'd0, d.has_param});
        else if (idx == IDX_ID0)
            b = (IDENT_BASE[7:0] | {5'd0, d.low}) + DOMAIN_ADD;
        else if (idx == IDX_ID1)
            b = IDENT_BASE[15:8] + DOMAIN_ADD;
        else if (idx == IDX_ID2)
            b = IDENT_BASE[23:16] + DOMAIN_ADD;
        else if (idx == IDX_ID3)
            b = IDENT_BASE[31:24] + DOMAIN_ADD;
        else if (idx < IDX_PARAM)
            b = PASSWORD[pwd_off[2:0]] + DOMAIN_ADD;
        else
            b = d.param + DOMAIN_ADD;
        return b;
    endfunction

endpackage

`default_nettype wire

/* src/mscf_cmd_if.sv */
// Command request channel: valid/ready handshake with the request fields.
// No dependencies.
`default_nettype none

interface mscf_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] param;
    logic       query;
    logic       flash;

    modport source (output valid, output kind, output param, output query,
                    output flash, input ready);
    modport sink   (input valid, input kind, input param, input query,
                    input flash, output ready);
endinterface

`default_nettype wire

/* src/mscf_frame_if.sv */
// Frame byte channel: valid/ready handshake with one byte and a last marker.
// No dependencies.
`default_nettype none

interface mscf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* src/mscf_front.sv */
// Front stage: accept a command transfer and classify it into a frame descriptor.
// Depends on mscf_pkg and mscf_cmd_if.
`default_nettype none

module mscf_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mscf_cmd_if.sink                  cmd,
    output mscf_pkg::frame_desc_t     desc,
    output logic                      desc_valid,
    input  wire logic                 desc_ready
);
    import mscf_pkg::*;

    logic        valid_reg, valid_next;
    frame_desc_t desc_reg, desc_next;
    frame_desc_t cls;
    logic        take;

    // Classify the command
    always_comb
    begin
        cls.query     = cmd.query;
        cls.param     = cmd.param;
        cls.has_param = 1'b0;
        cls.low       = LOW_NONE;
        unique case (kind_t'(cmd.kind))
            KIND_TUNE:
            begin
                cls.low       = cmd.flash ? LOW_TUNE_FLASH : LOW_TUNE;
                cls.has_param = 1'b1;
            end
            KIND_FLASH_GEAR, KIND_FREQ_GEAR:
            begin
                cls.low       = LOW_GEAR;
                cls.has_param = 1'b1;
            end
            KIND_WORKTIME:
            begin
                cls.low       = cmd.flash ? LOW_WORK_FLASH : LOW_WORK;
                cls.has_param = 1'b1;
            end
            KIND_LIGHTSENSE:
            begin
                cls.has_param = 1'b1;
            end
            KIND_SYNC_A, KIND_SYNC_B, KIND_SYNC_C:
            begin
                cls.low       = LOW_SYNC;
                cls.has_param = 1'b1;
            end
            default:
            begin
                cls.low       = LOW_NONE;
                cls.has_param = 1'b0;
            end
        endcase
    end

    assign cmd.ready  = !valid_reg || desc_ready;
    assign take       = cmd.valid && cmd.ready;
    assign desc       = desc_reg;
    assign desc_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (take)
        begin
            valid_next = 1'b1;
            desc_next  = cls;
        end
        else if (desc_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

`default_nettype wire

/* src/mscf_queue.sv */
// Two-entry descriptor queue between the front stage and the byte sequencer.
// Depends on mscf_pkg and the assertion macro header.
`default_nettype none
`include "meter_style_command_framer_core_assert.svh"

module mscf_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mscf_pkg::frame_desc_t push_desc,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    output mscf_pkg::frame_desc_t     pop_desc,
    output logic                      pop_valid,
    input  wire logic                 pop_ready
);
    import mscf_pkg::*;

    frame_desc_t entry_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push_fire, pop_fire;

    assign push_ready = count_reg != 2'(QDEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 2'd1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    `MSCF_ASSERT_NEXT(a_fill_grows, clk, rst_n, push_fire && !pop_fire, count_reg == $past(count_reg) + 2'd1)
    `MSCF_ASSERT_IMPLY(a_bounded, clk, rst_n, 1'b1, count_reg <= 2'(QDEPTH))

endmodule

`default_nettype wire

/* src/mscf_back.sv */
// Byte sequencer: walk one descriptor into frame bytes, add the checksum, register the output.
// Depends on mscf_pkg, mscf_frame_if and the assertion macro header.
`default_nettype none
`include "meter_style_command_framer_core_assert.svh"

module mscf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mscf_pkg::frame_desc_t q_desc,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    mscf_frame_if.source              frame
);
    import mscf_pkg::*;

    logic        busy_reg, busy_next;
    idx_t        idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    frame_desc_t desc_reg, desc_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        can_load, emit, is_last, pop;
    logic [7:0]  cur_byte;

    always_comb
    begin
        can_load = !ovalid_reg || frame.ready;
        emit     = busy_reg && can_load;
        is_last  = idx_reg == body_len(desc_reg);
        cur_byte = is_last ? sum_reg : frame_byte(desc_reg, idx_reg);
        pop      = q_valid && (!busy_reg || (emit && is_last));

        busy_next = busy_reg;
        if (emit && is_last)
            busy_next = 1'b0;
        if (pop)
            busy_next = 1'b1;

        desc_next = pop ? q_desc : desc_reg;

        idx_next = idx_reg;
        sum_next = sum_reg;
        if (pop)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 5'd1;
            sum_next = sum_reg + cur_byte;
        end

        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (can_load)
        begin
            ovalid_next = emit;
            obyte_next  = cur_byte;
            olast_next  = is_last;
        end
    end

    assign q_ready        = pop;
    assign frame.valid    = ovalid_reg;
    assign frame.out_byte = obyte_reg;
    assign frame.last     = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg  <= desc_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    `MSCF_ASSERT_NEXT(a_frame_continues, clk, rst_n, emit && !is_last, busy_reg)
    `MSCF_ASSERT_IMPLY(a_last_position, clk, rst_n, emit && is_last, (idx_reg == IDX_CSUM_QUERY) || (idx_reg == IDX_CSUM_WRITE) || (idx_reg == IDX_CSUM_PARAM))
    `MSCF_ASSERT_NEXT(a_load_clears, clk, rst_n, pop, (idx_reg == 5'd0) && (sum_reg == 8'd0))

endmodule

`default_nettype wire

/* src/meter_style_command_framer_core.sv */
// Top level of the meter-style command framer: front stage, queue and byte sequencer.
// Depends on mscf_pkg, mscf_cmd_if, mscf_frame_if, mscf_front, mscf_queue, mscf_back.
//
// Usage:
//   cmd   - command transfer in (kind, param, query, flash), valid/ready.
//   frame - frame bytes out (out_byte, last), valid/ready; last marks the
//           checksum byte that closes each frame.
// Counting the checksum, a query frame is 14 bytes, a write frame 22 bytes,
// or 23 when the command carries a parameter byte. The byte sequencer issues
// one byte per cycle while the receiver accepts them; the first byte of the
// next frame follows the previous checksum byte with no gap when a
// descriptor is waiting and the receiver keeps taking bytes.
// Path: when it is empty, the first byte of a frame passes the front
// register, the queue, the sequencer state and the sequencer output
// register before it appears on frame.
// The front stage and a two-entry queue keep taking commands while a frame
// is in progress; cmd.ready drops only when both are full.
// When the receiver stalls, the output register holds the byte and the
// sequencer waits; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the front stage, queue and
// sequencer; no frame is in flight afterwards.
`default_nettype none

module meter_style_command_framer_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mscf_cmd_if.sink    cmd,
    mscf_frame_if.source frame
);
    import mscf_pkg::*;

    // Descriptor from the front stage into the queue
    frame_desc_t front_desc;
    logic        front_valid;
    logic        front_ready;

    // Descriptor from the queue into the byte sequencer
    frame_desc_t q_desc;
    logic        q_valid;
    logic        q_ready;

    // Classify each command transfer into a frame descriptor
    mscf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .desc       (front_desc),
        .desc_valid (front_valid),
        .desc_ready (front_ready)
    );

    // Decouple classification from frame emission
    mscf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_desc  (front_desc),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_desc   (q_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    // Walk the descriptor out one byte per cycle while the receiver accepts, and append the checksum
    mscf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_desc  (q_desc),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .frame   (frame)
    );

endmodule

`default_nettype wire

/* sim/mscf_frame_checker.sv */
`timescale 1ns / 1ps
// Frame checker for the command framer: watches the command and frame channels,
// predicts every frame byte from each accepted command and compares on the fly.
// Depends on mscf_pkg, mscf_cmd_if and mscf_frame_if.

module mscf_frame_checker
    import mscf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mscf_cmd_if   cmd,
    mscf_frame_if frame,
    output int    fail_count,
    output int    pending
);

    localparam logic [7:0]  ADDR_FILL = 8'hAA;
    localparam logic [7:0]  SOF_BYTE  = 8'h68;
    localparam logic [7:0]  CTL_READ  = 8'h11;
    localparam logic [7:0]  CTL_WRITE = 8'h14;
    localparam logic [7:0]  OBFUSCATE = 8'h33;
    localparam logic [7:0]  READ_LEN  = 8'd4;
    localparam logic [7:0]  WRITE_LEN = 8'd12;
    localparam logic [31:0] DATA_ID   = 32'h0400_0300;
    // Sent first byte first, taken from the top down
    localparam logic [63:0] METER_KEY = 64'h02_00_00_00_0A_0B_0C_0D;

    // Low byte of the data identifier
    localparam logic [7:0] ID_PLAIN   = 8'h00;
    localparam logic [7:0] ID_GEAR    = 8'h02;
    localparam logic [7:0] ID_SYNC    = 8'h03;
    localparam logic [7:0] ID_WORK    = 8'h04;
    localparam logic [7:0] ID_WORK_FL = 8'h05;
    localparam logic [7:0] ID_TUNE    = 8'h06;
    localparam logic [7:0] ID_TUNE_FL = 8'h07;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t beats_due[$];
    logic [7:0]  running_sum;
    int          errs;

    function automatic void emit_byte(input logic [7:0] b);
        frame_beat_t t;
        t.data = b;
        t.last = 1'b0;
        beats_due.push_back(t);
        running_sum = running_sum + b;
    endfunction

    function automatic void predict_frame(input logic [3:0] kind, input logic [7:0] param,
                                          input logic query, input logic flash);
        logic [7:0]  id_low;
        logic        carries;
        frame_beat_t tail;
        int          i;
        id_low  = ID_PLAIN;
        carries = 1'b0;
        case (kind)
            KIND_TUNE:
            begin
                id_low  = flash ? ID_TUNE_FL : ID_TUNE;
                carries = 1'b1;
            end
            KIND_FLASH_GEAR, KIND_FREQ_GEAR:
            begin
                id_low  = ID_GEAR;
                carries = 1'b1;
            end
            KIND_WORKTIME:
            begin
                id_low  = flash ? ID_WORK_FL : ID_WORK;
                carries = 1'b1;
            end
            KIND_LIGHTSENSE:
            begin
                carries = 1'b1;
            end
            KIND_SYNC_A, KIND_SYNC_B, KIND_SYNC_C:
            begin
                id_low  = ID_SYNC;
                carries = 1'b1;
            end
            default:
            begin
                // unused codes frame like a state change
            end
        endcase

        running_sum = 8'h00;
        for (i = 0; i < 6; i++)
            emit_byte(ADDR_FILL);
        emit_byte(SOF_BYTE);
        emit_byte(query ? CTL_READ : CTL_WRITE);
        emit_byte(query ? READ_LEN : WRITE_LEN + {7'd0, carries});
        for (i = 0; i < 4; i++)
        begin
            if (i == 0)
                emit_byte((DATA_ID[7:0] | id_low) + OBFUSCATE);
            else
                emit_byte(DATA_ID[8*i +: 8] + OBFUSCATE);
        end
        if (!query)
        begin
            for (i = 0; i < 8; i++)
                emit_byte(METER_KEY[63 - 8*i -: 8] + OBFUSCATE);
            if (carries)
                emit_byte(param + OBFUSCATE);
        end
        tail.data = running_sum;
        tail.last = 1'b1;
        beats_due.push_back(tail);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (!rst_n)
        begin
            beats_due.delete();
            errs = 0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                got.data = frame.out_byte;
                got.last = frame.last;
                if (beats_due.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected frame byte, expected none, got %02h last %0b",
                             $time, got.data, got.last);
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (got.data !== want.data)
                    begin
                        errs++;
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, got.data);
                    end
                    if (got.last !== want.last)
                    begin
                        errs++;
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                predict_frame(cmd.kind, cmd.param, cmd.query, cmd.flash);
        end
        fail_count <= errs;
        pending    <= beats_due.size();
    end

endmodule

/* sim/tb_meter_style_command_framer_core.sv */
`timescale 1ns / 1ps
// Testbench top for the command framer: clock, reset, command stimulus,
// frame receiver stalls, watchdog and verdict. Depends on mscf_pkg, both
// channel interfaces, meter_style_command_framer_core and mscf_frame_checker.

module tb_meter_style_command_framer_core;

    import mscf_pkg::*;

    // Longest stretch without any transfer before the run is abandoned. The
    // deliberate receiver hold-off is the longest quiet spell in a good run.
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    // Quiet time after the last byte: covers the path latency.
    localparam int SETTLE_CYCLES = 20;

    // Receiver behaviour, re-chosen after each random span
    typedef enum int {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SLOW,    // ready one cycle in four
        RX_BEAT     // regular comb of short stalls
    } rx_mode_e;

    logic clk;
    logic rst_n;

    mscf_cmd_if   cmd_ch ();
    mscf_frame_if frame_ch ();

    int fails;
    int pending;

    // Sender shaping: items left in the current burst, and a switch that
    // suppresses gaps while the receiver is being held off.
    int   burst_left;
    logic steady;
    // Bumped by the stimulus for each hold-off; the receiver tracks its own copy
    int   hold_req;
    int   idle_cycles;

    meter_style_command_framer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .frame (frame_ch)
    );

    mscf_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .frame      (frame_ch),
        .fail_count (fails),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one command and hold it until the framer takes it. Unless steady is
    // set, insert a gap of random length before each new burst; within a burst
    // keep valid high so back-to-back transfers are exercised.
    task automatic send_cmd(input logic [3:0] kind, input logic [7:0] param,
                            input logic query, input logic flash);
        int gap;
        if (!steady && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= kind;
        cmd_ch.param <= param;
        cmd_ch.query <= query;
        cmd_ch.flash <= flash;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Drop valid and wait for every predicted byte to leave the framer.
    task automatic drain_frames();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        burst_left = 0;
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_cmd(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
    endtask

    // Frame receiver: pick a stall pattern, hold it for a while, then pick
    // another. A hold-off request overrides the pattern for HOLD_CYCLES.
    initial
    begin
        rx_mode_e mode;
        int       span;
        int       hold_left;
        int       hold_seen;
        frame_ch.ready = 1'b0;
        mode      = RX_OPEN;
        span      = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_req;
            end
            if (span == 0)
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                span = $urandom_range(10, 60);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN: frame_ch.ready <= 1'b1;
                    RX_COIN: frame_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: frame_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: frame_ch.ready <= (span % 5) != 0;
                endcase
            end
        end
    end

    // Watchdog: abandon the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int k;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind  = KIND_STATE;
        cmd_ch.param = 8'h00;
        cmd_ch.query = 1'b0;
        cmd_ch.flash = 1'b0;
        burst_left   = 0;
        steady       = 1'b0;
        hold_req     = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every command code as a write, the two unused codes
        // included, with the parameter at both extremes (0xFF wraps when
        // scrambled) and the flash flag toggling through the list.
        for (k = 0; k < 16; k++)
            send_cmd(4'(k), k[0] ? 8'hFF : 8'h00, 1'b0, k[1]);
        // Both identifier variants of tune and worktime
        send_cmd(KIND_TUNE, 8'h5A, 1'b0, 1'b1);
        send_cmd(KIND_WORKTIME, 8'hA5, 1'b0, 1'b0);
        // Queries: parameter commands still pick the identifier, but send
        // neither password nor parameter
        send_cmd(KIND_TUNE, 8'hFF, 1'b1, 1'b1);
        send_cmd(KIND_WORKTIME, 8'hFF, 1'b1, 1'b0);
        send_cmd(KIND_SYNC_B, 8'h80, 1'b1, 1'b1);
        send_cmd(KIND_FLASH_GEAR, 8'h01, 1'b1, 1'b0);
        send_cmd(KIND_STATE, 8'h00, 1'b1, 1'b0);
        send_cmd(4'd15, 8'hFF, 1'b1, 1'b1);

        // Pause until the framer is empty before the random run
        drain_frames();
        send_random(40);

        // Back-pressure: hold the receiver off while offering commands with
        // no gaps, so the front stage and queue fill and cmd.ready drops.
        hold_req++;
        steady   = 1'b1;
        send_random(8);
        steady   = 1'b0;
        drain_frames();

        send_random(28);

        // Wind down: let the last frame out, then watch for stray bytes.
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
